/* design/tlik_pkg.sv */
// shared types, constants and the arctangent table for the two-link arm solver
`timescale 1ns / 1ps

package tlik_pkg;

    localparam int ANG_W = 9;
    localparam int POS_W = 14;
    localparam int LEN_W = 12;

    // short input queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;
    localparam int Q_CW = 3;

    // cordic datapath
    localparam int CIN_W = 32;
    localparam int CXY_W = 35;
    localparam int CZ_W = 26;
    localparam int ATAN_TAB_LEN = 24;
    localparam logic signed [CZ_W-1:0] DEG90 = 26'sd5898240;

    localparam logic [15:0] SHOULDER_MAX = 16'd46080;
    localparam logic [15:0] RIGHT_ANGLE = 16'd23040;

    localparam logic REG_UPPER_LEN = 1'b0;
    localparam logic REG_LOWER_LEN = 1'b1;

    typedef struct packed {
        logic signed [ANG_W-1:0] ang;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } tlik_item_t;

    typedef struct packed {
        logic                    vld;
        logic signed [ANG_W-1:0] ang;
        logic                    orig;
        logic                    unr;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } tlik_ctl_t;

    typedef struct packed {
        tlik_ctl_t   ctl;
        logic [25:0] r2;
        logic [37:0] r2l1;
    } tlik_sq1_t;

    typedef struct packed {
        tlik_ctl_t   ctl;
        logic        neg;
        logic [29:0] cn;
        logic [25:0] r2;
        logic [25:0] b;
    } tlik_sq2_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [CZ_W-1:0] atan_entry(input int idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            0: v = 26'sd2949120;
            1: v = 26'sd1740967;
            2: v = 26'sd919879;
            3: v = 26'sd466945;
            4: v = 26'sd234379;
            5: v = 26'sd117304;
            6: v = 26'sd58666;
            7: v = 26'sd29335;
            8: v = 26'sd14668;
            9: v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

/* design/tlik_front.sv */
// input side: range check of each target and the short queue towards the solver
`timescale 1ns / 1ps

module tlik_front
    import tlik_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [ANG_W-1:0] s_base_angle_in,
    input  logic signed [POS_W-1:0] s_target_x,
    input  logic signed [POS_W-1:0] s_target_y,
    input  logic                    s_done_flag,
    input  logic [LEN_W-1:0]        upper_len,
    input  logic [LEN_W-1:0]        lower_len,
    output logic                    q_valid,
    output tlik_item_t              q_item,
    input  logic                    q_pop
);

    localparam logic signed [ANG_W-1:0] ANG_MAX = 9'sd180;
    localparam logic signed [ANG_W-1:0] SENT_ANG = -9'sd1;
    localparam logic signed [POS_W-1:0] SENT_X = -14'sd256;

    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] cnt_reg;
    tlik_item_t      buf_reg [Q_DEPTH];

    logic                    in_range, is_sentinel, push;
    logic [LEN_W:0]          reach;
    logic signed [POS_W:0]   y_ext, l1_ext;

    assign reach  = {1'b0, upper_len} + {1'b0, lower_len};
    assign y_ext  = (POS_W+1)'(s_target_y);
    assign l1_ext = $signed({3'b000, upper_len});

    assign in_range = !s_base_angle_in[ANG_W-1] && (s_base_angle_in <= ANG_MAX)
                   && !s_target_x[POS_W-1] && (s_target_x[POS_W-2:0] <= reach)
                   && (y_ext >= -l1_ext) && (y_ext <= l1_ext);
    assign is_sentinel = (s_base_angle_in == SENT_ANG) && (s_target_x == SENT_X)
                      && s_done_flag;

    assign s_ready = (cnt_reg != Q_CW'(Q_DEPTH));
    // out-of-range targets are taken and dropped
    assign push    = s_valid && s_ready && (in_range || is_sentinel);

    assign q_valid = (cnt_reg != '0);
    assign q_item  = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push && q_pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= '{ang: s_base_angle_in, x: s_target_x, y: s_target_y};
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= Q_CW'(Q_DEPTH))
        else $error("queue fill beyond depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> cnt_reg != '0)
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !q_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push not counted");

endmodule

/* design/tlik_isqrt.sv */
// pipelined floor square root, one root bit per stage, with a sideband carried alongside
`timescale 1ns / 1ps

module tlik_isqrt
    import tlik_pkg::*;
#(
    parameter int RAD_W  = 52,
    parameter int SIDE_W = 8
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [RAD_W-1:0]      rad_in,
    input  logic [SIDE_W-1:0]     side_in,
    output logic [RAD_W/2-1:0]    root_out,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int N = RAD_W / 2;

    logic [RAD_W-1:0]  rad_reg  [N];
    logic [N+1:0]      rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [SIDE_W-1:0] side_reg [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic [RAD_W-1:0]  rad_p;
        logic [N+1:0]      rem_p, rem_sh, trial;
        logic [N-1:0]      root_p;
        logic [SIDE_W-1:0] side_p;
        logic              ge;

        if (j == 0) begin : g_first
            assign rad_p  = rad_in;
            assign rem_p  = '0;
            assign root_p = '0;
            assign side_p = side_in;
        end else begin : g_rest
            assign rad_p  = rad_reg[j-1];
            assign rem_p  = rem_reg[j-1];
            assign root_p = root_reg[j-1];
            assign side_p = side_reg[j-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_sh = {rem_p[N-1:0], rad_p[RAD_W-1:RAD_W-2]};
        assign trial  = {root_p, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[j] <= '0;
            end else if (en) begin
                side_reg[j] <= side_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j]  <= {rad_p[RAD_W-3:0], 2'b00};
                rem_reg[j]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[j] <= {root_p[N-2:0], ge};
            end
        end
    end

    assign root_out = root_reg[N-1];
    assign side_out = side_reg[N-1];

endmodule

/* design/tlik_cordic.sv */
// pipelined cordic vectoring unit giving atan2(num, den) in 2^-16 degree
`timescale 1ns / 1ps

module tlik_cordic
    import tlik_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic signed [CIN_W-1:0] num,
    input  logic signed [CIN_W-1:0] den,
    input  logic [SIDE_W-1:0]       side_in,
    output logic signed [CZ_W-1:0]  z_out,
    output logic [SIDE_W-1:0]       side_out
);

    // normalising stage
    logic signed [CIN_W-1:0] n1_num_reg, n1_den_reg;
    logic [4:0]              n1_k_reg;
    logic                    n1_zero_reg;
    logic [SIDE_W-1:0]       n1_side_reg;

    logic [CIN_W-1:0] mag_n, mag_d, mag_or;
    logic [4:0]       msb, k_next;

    assign mag_n  = num[CIN_W-1] ? CIN_W'(-num) : CIN_W'(num);
    assign mag_d  = den[CIN_W-1] ? CIN_W'(-den) : CIN_W'(den);
    assign mag_or = mag_n | mag_d;

    always_comb begin
        msb = '0;
        for (int i = 0; i < CIN_W; i++) begin
            if (mag_or[i]) begin
                msb = 5'(i);
            end
        end
        k_next = (msb >= 5'd29) ? 5'd0 : 5'd29 - msb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_side_reg <= '0;
        end else if (en) begin
            n1_side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_num_reg  <= num;
            n1_den_reg  <= den;
            n1_k_reg    <= k_next;
            n1_zero_reg <= (mag_or == '0);
        end
    end

    // scale up and fold the left half-plane into the right
    logic signed [CXY_W-1:0] n2_x_reg, n2_y_reg;
    logic signed [CZ_W-1:0]  n2_z_reg;
    logic                    n2_zero_reg;
    logic [SIDE_W-1:0]       n2_side_reg;

    logic signed [CXY_W-1:0] xs, ys, x_next, y_next;
    logic signed [CZ_W-1:0]  z_next;

    assign xs = CXY_W'(n1_den_reg) <<< n1_k_reg;
    assign ys = CXY_W'(n1_num_reg) <<< n1_k_reg;

    always_comb begin
        x_next = xs;
        y_next = ys;
        z_next = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                x_next = ys;
                y_next = -xs;
                z_next = DEG90;
            end else begin
                x_next = -ys;
                y_next = xs;
                z_next = -DEG90;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n2_side_reg <= '0;
        end else if (en) begin
            n2_side_reg <= n1_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_x_reg    <= x_next;
            n2_y_reg    <= y_next;
            n2_z_reg    <= z_next;
            n2_zero_reg <= n1_zero_reg;
        end
    end

    // micro-rotations
    logic signed [CXY_W-1:0] x_reg    [STAGES];
    logic signed [CXY_W-1:0] y_reg    [STAGES];
    logic signed [CZ_W-1:0]  z_reg    [STAGES];
    logic                    zero_reg [STAGES];
    logic [SIDE_W-1:0]       side_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [CXY_W-1:0] xp, yp, dx, dy;
        logic signed [CZ_W-1:0]  zp;
        logic                    zerop;
        logic [SIDE_W-1:0]       sidep;

        if (i == 0) begin : g_first
            assign xp    = n2_x_reg;
            assign yp    = n2_y_reg;
            assign zp    = n2_z_reg;
            assign zerop = n2_zero_reg;
            assign sidep = n2_side_reg;
        end else begin : g_rest
            assign xp    = x_reg[i-1];
            assign yp    = y_reg[i-1];
            assign zp    = z_reg[i-1];
            assign zerop = zero_reg[i-1];
            assign sidep = side_reg[i-1];
        end

        assign dx = yp >>> i;
        assign dy = xp >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i] <= '0;
            end else if (en) begin
                side_reg[i] <= sidep;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i] <= zerop;
                if (yp > 0) begin
                    x_reg[i] <= xp + dx;
                    y_reg[i] <= yp - dy;
                    z_reg[i] <= zp + atan_entry(i);
                end else begin
                    x_reg[i] <= xp - dx;
                    y_reg[i] <= yp + dy;
                    z_reg[i] <= zp - atan_entry(i);
                end
            end
        end
    end

    assign z_out    = zero_reg[STAGES-1] ? '0 : z_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];

endmodule

/* design/tlik_back.sv */
// solver pipeline: squares, two square roots, three cordic runs and the output register
`timescale 1ns / 1ps

module tlik_back
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [LEN_W-1:0]        upper_len,
    input  logic [LEN_W-1:0]        lower_len,
    input  logic                    q_valid,
    input  tlik_item_t              q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ANG_W-1:0] m_base_angle_out,
    output logic [15:0]             m_shoulder_angle,
    output logic signed [17:0]      m_elbow_angle,
    output logic                    m_unreachable
);

    logic adv;

    logic                    m_valid_reg;
    logic signed [ANG_W-1:0] m_ang_reg;
    logic [15:0]             m_shoulder_reg;
    logic signed [17:0]      m_elbow_reg;
    logic                    m_unr_reg;

    // whole pipeline moves together; it only stops while a result waits
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = q_valid && adv;

    // ---------------- squares up to the first root
    tlik_ctl_t c1_reg, c2_reg, c3_reg, c4_reg;

    logic [26:0] st1_xx_reg, st1_yy_reg;
    logic [23:0] st1_l2sq_reg;
    logic [27:0] st2_r2_reg;
    logic [25:0] st2_lim_reg;
    logic [25:0] st3_r2_reg, st3_diff_reg;
    logic [37:0] st3_r2l1_reg;
    logic [25:0] st4_r2_reg;
    logic [37:0] st4_r2l1_reg;
    logic [51:0] st4_rad_reg;

    logic signed [27:0] x_ext, y_ext, xx_full, yy_full;
    logic               far_next;

    assign x_ext   = 28'(q_item.x);
    assign y_ext   = 28'(q_item.y);
    assign xx_full = x_ext * x_ext;
    assign yy_full = y_ext * y_ext;
    assign far_next = (st2_r2_reg > {2'b00, st2_lim_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end else if (adv) begin
            c1_reg <= '{vld: q_valid, ang: q_item.ang, orig: 1'b0, unr: 1'b0,
                        x: q_item.x, y: q_item.y};
            c2_reg <= '{vld: c1_reg.vld, ang: c1_reg.ang,
                        orig: (c1_reg.x == '0) && (c1_reg.y == '0),
                        unr: c1_reg.unr, x: c1_reg.x, y: c1_reg.y};
            c3_reg <= '{vld: c2_reg.vld, ang: c2_reg.ang, orig: c2_reg.orig,
                        unr: far_next, x: c2_reg.x, y: c2_reg.y};
            c4_reg <= c3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_xx_reg   <= xx_full[26:0];
            st1_yy_reg   <= yy_full[26:0];
            st1_l2sq_reg <= 24'(lower_len) * 24'(lower_len);
            st2_r2_reg   <= 28'(st1_xx_reg) + 28'(st1_yy_reg);
            st2_lim_reg  <= {st1_l2sq_reg, 2'b00};
            st3_r2_reg   <= st2_r2_reg[25:0];
            st3_diff_reg <= far_next ? '0 : st2_lim_reg - st2_r2_reg[25:0];
            st3_r2l1_reg <= 38'(st2_r2_reg[25:0]) * 38'(upper_len);
            st4_r2_reg   <= st3_r2_reg;
            st4_r2l1_reg <= st3_r2l1_reg;
            st4_rad_reg  <= 52'(st3_r2_reg) * 52'(st3_diff_reg);
        end
    end

    tlik_sq1_t   sq1_in, sq1_out;
    logic [25:0] root_b;

    assign sq1_in = '{ctl: c4_reg, r2: st4_r2_reg, r2l1: st4_r2l1_reg};

    tlik_isqrt #(
        .RAD_W  (52),
        .SIDE_W ($bits(tlik_sq1_t))
    ) u_isqrt_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .rad_in   (st4_rad_reg),
        .side_in  (sq1_in),
        .root_out (root_b),
        .side_out (sq1_out)
    );

    // ---------------- arccosine argument and its domain check
    tlik_ctl_t c5_reg, c6_reg, c7_reg, c8_reg, c9_reg, c10_reg, c11_reg;

    logic [25:0]        st5_r2_reg, st6_r2_reg, st7_r2_reg, st8_r2_reg, st9_r2_reg;
    logic [25:0]        st10_r2_reg, st11_r2_reg;
    logic [25:0]        st5_b_reg, st6_b_reg, st7_b_reg, st8_b_reg, st9_b_reg;
    logic [25:0]        st10_b_reg, st11_b_reg;
    logic [37:0]        st5_r2l1_reg;
    logic signed [40:0] st5_p1_reg, st5_p2_reg;
    logic signed [41:0] st6_c_reg;
    logic [38:0]        st6_d_reg, st7_d_reg, st8_d_reg;
    logic [40:0]        st7_cm_reg, st8_cm_reg;
    logic               st7_neg_reg, st8_neg_reg, st9_neg_reg, st10_neg_reg, st11_neg_reg;
    logic [3:0]         st8_sh_reg;
    logic [29:0]        st9_dn_reg, st9_cn_reg, st10_cn_reg, st11_cn_reg;
    logic [29:0]        st10_dm_reg;
    logic [30:0]        st10_dp_reg;
    logic [61:0]        st11_rad_reg;

    logic signed [40:0] r2_s, b_s, x41, y41;
    logic [40:0]        c_mag;
    logic               dom_bad;
    logic [3:0]         sh_next;
    logic [38:0]        dn_full;
    logic [40:0]        cn_full;

    assign r2_s = 41'($signed({1'b0, sq1_out.r2}));
    assign b_s  = 41'($signed({1'b0, root_b}));
    assign x41  = 41'(sq1_out.ctl.x);
    assign y41  = 41'(sq1_out.ctl.y);

    assign c_mag   = st6_c_reg[41] ? 41'(-st6_c_reg) : st6_c_reg[40:0];
    assign dom_bad = (st6_d_reg == '0) || (c_mag > {2'b00, st6_d_reg});

    // right shifts that bring D below 2^30
    always_comb begin
        sh_next = '0;
        for (int i = 30; i < 39; i++) begin
            if (st7_d_reg[i]) begin
                sh_next = 4'(i - 29);
            end
        end
    end

    assign dn_full = st8_d_reg >> st8_sh_reg;
    assign cn_full = st8_cm_reg >> st8_sh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c5_reg  <= '0;
            c6_reg  <= '0;
            c7_reg  <= '0;
            c8_reg  <= '0;
            c9_reg  <= '0;
            c10_reg <= '0;
            c11_reg <= '0;
        end else if (adv) begin
            c5_reg  <= sq1_out.ctl;
            c6_reg  <= c5_reg;
            c7_reg  <= '{vld: c6_reg.vld, ang: c6_reg.ang, orig: c6_reg.orig,
                         unr: c6_reg.unr || dom_bad, x: c6_reg.x, y: c6_reg.y};
            c8_reg  <= c7_reg;
            c9_reg  <= c8_reg;
            c10_reg <= c9_reg;
            c11_reg <= c10_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st5_r2_reg   <= sq1_out.r2;
            st5_b_reg    <= root_b;
            st5_r2l1_reg <= sq1_out.r2l1;
            st5_p1_reg   <= r2_s * x41;
            st5_p2_reg   <= y41 * b_s;

            st6_r2_reg   <= st5_r2_reg;
            st6_b_reg    <= st5_b_reg;
            st6_c_reg    <= 42'(st5_p1_reg) - 42'(st5_p2_reg);
            st6_d_reg    <= {st5_r2l1_reg, 1'b0};

            st7_r2_reg   <= st6_r2_reg;
            st7_b_reg    <= st6_b_reg;
            st7_cm_reg   <= c_mag;
            st7_neg_reg  <= st6_c_reg[41];
            st7_d_reg    <= st6_d_reg;

            st8_r2_reg   <= st7_r2_reg;
            st8_b_reg    <= st7_b_reg;
            st8_cm_reg   <= st7_cm_reg;
            st8_neg_reg  <= st7_neg_reg;
            st8_d_reg    <= st7_d_reg;
            st8_sh_reg   <= sh_next;

            st9_r2_reg   <= st8_r2_reg;
            st9_b_reg    <= st8_b_reg;
            st9_neg_reg  <= st8_neg_reg;
            st9_dn_reg   <= dn_full[29:0];
            st9_cn_reg   <= cn_full[29:0];

            st10_r2_reg  <= st9_r2_reg;
            st10_b_reg   <= st9_b_reg;
            st10_neg_reg <= st9_neg_reg;
            st10_cn_reg  <= st9_cn_reg;
            st10_dm_reg  <= st9_dn_reg - st9_cn_reg;
            st10_dp_reg  <= 31'(st9_dn_reg) + 31'(st9_cn_reg);

            st11_r2_reg  <= st10_r2_reg;
            st11_b_reg   <= st10_b_reg;
            st11_neg_reg <= st10_neg_reg;
            st11_cn_reg  <= st10_cn_reg;
            st11_rad_reg <= 62'(st10_dm_reg) * 62'(st10_dp_reg);
        end
    end

    tlik_sq2_t   sq2_in, sq2_out;
    logic [30:0] root_h;

    assign sq2_in = '{ctl: c11_reg, neg: st11_neg_reg, cn: st11_cn_reg,
                      r2: st11_r2_reg, b: st11_b_reg};

    tlik_isqrt #(
        .RAD_W  (62),
        .SIDE_W ($bits(tlik_sq2_t))
    ) u_isqrt_h (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .rad_in   (st11_rad_reg),
        .side_in  (sq2_in),
        .root_out (root_h),
        .side_out (sq2_out)
    );

    // ---------------- three angle runs side by side
    logic signed [CIN_W-1:0] sho_num, sho_den, e1_num, e1_den, e2_num, e2_den;
    logic signed [CZ_W-1:0]  z_sho, z_e1, z_e2;
    logic [ANG_W:0]          sho_side_in, sho_side_out;
    logic                    e1_orig, e2_unr;

    assign sho_num = $signed({1'b0, root_h});
    assign sho_den = sq2_out.neg ? -$signed({2'b00, sq2_out.cn}) : $signed({2'b00, sq2_out.cn});
    assign e1_num  = CIN_W'(sq2_out.ctl.x);
    assign e1_den  = CIN_W'(sq2_out.ctl.y);
    assign e2_num  = $signed({6'b000000, sq2_out.r2});
    assign e2_den  = $signed({6'b000000, sq2_out.b});

    assign sho_side_in = {sq2_out.ctl.vld, sq2_out.ctl.ang};

    tlik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (ANG_W + 1)
    ) u_cordic_sho (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .num      (sho_num),
        .den      (sho_den),
        .side_in  (sho_side_in),
        .z_out    (z_sho),
        .side_out (sho_side_out)
    );

    tlik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (1)
    ) u_cordic_tgt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .num      (e1_num),
        .den      (e1_den),
        .side_in  (sq2_out.ctl.orig),
        .z_out    (z_e1),
        .side_out (e1_orig)
    );

    tlik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (1)
    ) u_cordic_off (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .num      (e2_num),
        .den      (e2_den),
        .side_in  (sq2_out.ctl.unr),
        .z_out    (z_e2),
        .side_out (e2_unr)
    );

    // ---------------- unit conversion, clamping and special cases
    logic                    f1_vld_reg;
    logic signed [ANG_W-1:0] f1_ang_reg;
    logic                    f1_orig_reg, f1_unr_reg;
    logic signed [CZ_W:0]    f1_ez_reg;
    logic signed [CZ_W-1:0]  f1_zs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (adv) begin
            f1_vld_reg <= sho_side_out[ANG_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_ang_reg  <= sho_side_out[ANG_W-1:0];
            f1_orig_reg <= e1_orig;
            f1_unr_reg  <= e2_unr;
            f1_ez_reg   <= (CZ_W+1)'(z_e1) - (CZ_W+1)'(z_e2);
            f1_zs_reg   <= z_sho;
        end
    end

    logic signed [CZ_W:0]   ez_rnd, ez_deg;
    logic signed [CZ_W-1:0] zs_rnd, zs_deg;
    logic [15:0]            sho_clamped, sho_next;
    logic signed [17:0]     elb_next;

    assign ez_rnd = f1_ez_reg + 27'sd128;
    assign ez_deg = ez_rnd >>> 8;
    assign zs_rnd = f1_zs_reg + 26'sd128;
    assign zs_deg = zs_rnd >>> 8;

    always_comb begin
        if (zs_deg < 0) begin
            sho_clamped = '0;
        end else if (zs_deg > $signed({10'b0, SHOULDER_MAX})) begin
            sho_clamped = SHOULDER_MAX;
        end else begin
            sho_clamped = zs_deg[15:0];
        end
        if (f1_orig_reg) begin
            sho_next = RIGHT_ANGLE;
            elb_next = $signed({2'b00, RIGHT_ANGLE});
        end else if (f1_unr_reg) begin
            sho_next = '0;
            elb_next = '0;
        end else begin
            sho_next = sho_clamped;
            elb_next = ez_deg[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_ang_reg      <= f1_ang_reg;
            m_shoulder_reg <= sho_next;
            m_elbow_reg    <= elb_next;
            m_unr_reg      <= f1_unr_reg && !f1_orig_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_base_angle_out = m_ang_reg;
    assign m_shoulder_angle = m_shoulder_reg;
    assign m_elbow_angle    = m_elbow_reg;
    assign m_unreachable    = m_unr_reg;

    a_shoulder_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_shoulder_reg <= SHOULDER_MAX)
        else $error("shoulder angle beyond clamp");

    a_unr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_unr_reg |-> m_shoulder_reg == '0 && m_elbow_reg == '0)
        else $error("unreachable beat with nonzero angles");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        c1_reg.vld && !adv |=> c1_reg.vld)
        else $error("first stage lost an item while stalled");

endmodule

/* design/two_link_arm_inverse_kinematics_top.sv */
// top level of the two-link arm inverse kinematics solver
`timescale 1ns / 1ps

// Solves a two-link planar arm for one target per beat.
// Input channel s_*: base angle, target x,y (1/256 inch) and done flag.
// Targets with angle outside 0..180, x outside 0..L1+L2 or y outside
// +-L1 are taken and dropped, unless they are the end sentinel
// (angle -1, x -256, done 1). Every kept target gives one beat on m_*:
// base angle passed through, shoulder and elbow angle in 1/256 degree,
// and the unreachable flag (both angles then zero).
// Link lengths are written through cfg_*: index 0 upper link, index 1
// lower link, reset value 816 each; write only while the block is empty.
// Most of the path from input beat to result lies in the two
// bit-per-stage square roots and the cordic chain. A new target is
// taken every cycle while the solver pipeline is not held.
// When a result waits and m_ready is low the whole solver pipeline holds; a
// four-entry queue at the input keeps s_ready high until it fills.
// Reset is synchronous, active low, empties queue and pipeline.
module two_link_arm_inverse_kinematics_top
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [ANG_W-1:0] s_base_angle_in,
    input  logic signed [POS_W-1:0] s_target_x,
    input  logic signed [POS_W-1:0] s_target_y,
    input  logic                    s_done_flag,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ANG_W-1:0] m_base_angle_out,
    output logic [15:0]             m_shoulder_angle,
    output logic signed [17:0]      m_elbow_angle,
    output logic                    m_unreachable,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [LEN_W-1:0]        cfg_data
);

    logic [LEN_W-1:0] upper_len_reg, lower_len_reg;
    logic             q_valid, q_pop;
    tlik_item_t       q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= 12'd816;
            lower_len_reg <= 12'd816;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_UPPER_LEN: upper_len_reg <= cfg_data;
                REG_LOWER_LEN: lower_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tlik_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_base_angle_in (s_base_angle_in),
        .s_target_x      (s_target_x),
        .s_target_y      (s_target_y),
        .s_done_flag     (s_done_flag),
        .upper_len       (upper_len_reg),
        .lower_len       (lower_len_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    tlik_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .upper_len        (upper_len_reg),
        .lower_len        (lower_len_reg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_base_angle_out (m_base_angle_out),
        .m_shoulder_angle (m_shoulder_angle),
        .m_elbow_angle    (m_elbow_angle),
        .m_unreachable    (m_unreachable)
    );

endmodule
